// File: hdl/u2c_pkg.sv
// ----------------------------------------------------------------------------
// u2c_pkg: shared constants, types and helpers for unix_time_to_calendar
// Field widths, reciprocal constants for the fixed divisors, the cumulative
// month table and the leap test used across the pipeline.
// ----------------------------------------------------------------------------
package u2c_pkg;

  // Port field widths
  localparam int SECS_W  = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int WDAY_W  = 3;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // Internal widths
  localparam int DAYS_W  = 16;  // days since epoch, up to 49710
  localparam int TOD_W   = 17;  // seconds in day, below 86400
  localparam int QUAD_W  = 6;   // four-year periods, up to 34
  localparam int DOY_W   = 11;  // day in four-year period, below 1461
  localparam int DOY9_W  = 9;   // day in year, below 366
  localparam int REST_W  = 12;  // seconds in hour, below 3600
  localparam int WEEKS_W = 13;  // whole weeks, up to 7102
  localparam int STEP_W  = 3;   // years stepped off, up to 4

  // Calendar constants
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_PER_QUAD = 4 * 365 + 1;
  localparam int DAYS_PER_YEAR = 365;
  localparam int DAYS_PER_LEAP = 366;
  localparam int DAYS_PER_WEEK = 7;
  localparam int EPOCH_WDAY    = 4;     // 1970-01-01 was a Thursday
  localparam int BASE_YEAR     = 1970;
  localparam int SKIP_LEAP     = 2100;  // only non-leap multiple of four in range
  localparam int YEAR_STEPS    = 4;
  localparam int MONTHS        = 12;
  localparam int MARCH         = 2;

  // Reciprocals: floor(x / d) = (x * ceil(2^k / d)) >> k for x < 2^n,
  // with k = n + ceil(log2(d)).
  localparam int DAY_PRE_SHIFT = 7;     // 86400 = 2^7 * 675
  localparam int DAY_ODD       = 675;
  localparam int DAY_SHIFT     = 35;
  localparam int DAY_RECIP_W   = 26;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
    DAY_RECIP_W'(((64'd1 << DAY_SHIFT) + DAY_ODD - 1) / DAY_ODD);
  localparam int DAY_PROD_W    = SECS_W - DAY_PRE_SHIFT + DAY_RECIP_W;

  localparam int QUAD_SHIFT    = 27;
  localparam int QUAD_RECIP_W  = 17;
  localparam logic [QUAD_RECIP_W-1:0] QUAD_RECIP =
    QUAD_RECIP_W'(((64'd1 << QUAD_SHIFT) + DAYS_PER_QUAD - 1) / DAYS_PER_QUAD);
  localparam int QUAD_PROD_W   = DAYS_W + QUAD_RECIP_W;

  localparam int WEEK_IN_W     = 17;
  localparam int WEEK_SHIFT    = 20;
  localparam int WEEK_RECIP_W  = 18;
  localparam logic [WEEK_RECIP_W-1:0] WEEK_RECIP =
    WEEK_RECIP_W'(((64'd1 << WEEK_SHIFT) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK);
  localparam int WEEK_PROD_W   = WEEK_IN_W + WEEK_RECIP_W;

  localparam int HOUR_SHIFT    = 29;
  localparam int HOUR_RECIP_W  = 18;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
    HOUR_RECIP_W'(((64'd1 << HOUR_SHIFT) + SECS_PER_HOUR - 1) / SECS_PER_HOUR);
  localparam int HOUR_PROD_W   = TOD_W + HOUR_RECIP_W;

  localparam int MIN_SHIFT     = 18;
  localparam int MIN_RECIP_W   = 13;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
    MIN_RECIP_W'(((64'd1 << MIN_SHIFT) + SECS_PER_MIN - 1) / SECS_PER_MIN);
  localparam int MIN_PROD_W    = REST_W + MIN_RECIP_W;

  localparam logic [DOY9_W-1:0] CUM_DAYS [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [DAYS_W-1:0]  days;
    logic [QUAD_W-1:0]  quads;
    logic [WEEKS_W-1:0] weeks;
  } u2c_day_t;

  // Exact Gregorian test over 1970..2106
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_W'(SKIP_LEAP));
  endfunction

  function automatic logic [DOY9_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DOY9_W-1:0] base;
    base = (m < MONTH_W'(MONTHS)) ? CUM_DAYS[m] : '0;
    return base + DOY9_W'(leap && (m >= MONTH_W'(MARCH)));
  endfunction

endpackage

// File: hdl/unix_time_to_calendar.sv
// ----------------------------------------------------------------------------
// unix_time_to_calendar: seconds since 1970 to UTC calendar fields
// Converts a 32-bit unsigned epoch count into year, month, day, weekday,
// hour, minute and second in a six-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_stall is low and returns one result beat
// per input beat, in order. The depth comes from the constant divisions,
// each a multiply by a reciprocal followed in the next stage by a
// multiply-back and subtract (days, then four-year periods and weeks), and
// from the year step-off and month search. A stall on a waiting result beat
// freezes all stages and raises in_stall in the same cycle. Every input
// value is valid; the leap rule treats 2100 as a common year and dates after
// it follow the fixed 1461-day periods.
module unix_time_to_calendar (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u2c_pkg::SECS_W-1:0]    in_epoch_seconds,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u2c_pkg::YEAR_W-1:0]    out_year_value,
  output logic [u2c_pkg::MONTH_W-1:0]   out_month_index,
  output logic [u2c_pkg::MDAY_W-1:0]    out_day_of_month,
  output logic [u2c_pkg::WDAY_W-1:0]    out_day_of_week,
  output logic [u2c_pkg::HOUR_W-1:0]    out_hour_of_day,
  output logic [u2c_pkg::MIN_W-1:0]     out_minute_of_hour,
  output logic [u2c_pkg::SEC_W-1:0]     out_second_of_minute
);
  import u2c_pkg::*;

  logic             adv;
  logic             front_vld;
  logic [TOD_W-1:0] front_tod;
  u2c_day_t         front_day;

  // Hold every stage while the result beat waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  u2c_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (in_valid),
    .secs_i (in_epoch_seconds),
    .vld_o  (front_vld),
    .tod_o  (front_tod),
    .day_o  (front_day)
  );

  u2c_clock u_clock (
    .clk    (clk),
    .adv    (adv),
    .tod_i  (front_tod),
    .hour_o (out_hour_of_day),
    .min_o  (out_minute_of_hour),
    .sec_o  (out_second_of_minute)
  );

  u2c_date u_date (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_i   (front_vld),
    .day_i   (front_day),
    .vld_o   (out_valid),
    .year_o  (out_year_value),
    .month_o (out_month_index),
    .mday_o  (out_day_of_month),
    .wday_o  (out_day_of_week)
  );

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_value >= YEAR_W'(BASE_YEAR)) &&
                  (out_year_value <= YEAR_W'(2106)))
    else $error("year out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index < MONTH_W'(MONTHS)) &&
                  (out_day_of_month != '0) && (out_day_of_week < WDAY_W'(DAYS_PER_WEEK)))
    else $error("month, day or weekday out of range");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_month_index == MONTH_W'(1))) |->
      (out_day_of_month <= MDAY_W'(29)))
    else $error("february day out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_of_day < HOUR_W'(24)) &&
                  (out_minute_of_hour < MIN_W'(SECS_PER_MIN)) &&
                  (out_second_of_minute < SEC_W'(SECS_PER_MIN)))
    else $error("time of day out of range");

endmodule

// File: hdl/u2c_front.sv
// ----------------------------------------------------------------------------
// u2c_front: day split, pipeline stages one and two
// Divides the seconds count into days, then splits off the time of day,
// the four-year period count and the whole-week count.
// ----------------------------------------------------------------------------
module u2c_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_i,
  input  logic [u2c_pkg::SECS_W-1:0]    secs_i,
  output logic                          vld_o,
  output logic [u2c_pkg::TOD_W-1:0]     tod_o,
  output u2c_pkg::u2c_day_t             day_o
);
  import u2c_pkg::*;

  logic [DAY_PROD_W-1:0]  day_prod;
  logic [SECS_W-1:0]      day_secs;
  logic [QUAD_PROD_W-1:0] quad_prod;
  logic [WEEK_IN_W-1:0]   week_in;
  logic [WEEK_PROD_W-1:0] week_prod;

  logic                   a_vld_r, a_vld_nxt;
  logic [SECS_W-1:0]      a_secs_r, a_secs_nxt;
  logic [DAYS_W-1:0]      a_days_r, a_days_nxt;

  logic                   b_vld_r, b_vld_nxt;
  logic [TOD_W-1:0]       b_tod_r, b_tod_nxt;
  u2c_day_t               b_day_r, b_day_nxt;

  // Stage one: days = secs / 86400
  always_comb begin
    day_prod   = DAY_PROD_W'(secs_i[SECS_W-1:DAY_PRE_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
    a_vld_nxt  = vld_i;
    a_secs_nxt = secs_i;
    a_days_nxt = DAYS_W'(day_prod >> DAY_SHIFT);
  end

  // Stage two: time of day, four-year periods, whole weeks
  always_comb begin
    day_secs  = SECS_W'(a_days_r) * SECS_W'(SECS_PER_DAY);
    quad_prod = QUAD_PROD_W'(a_days_r) * QUAD_PROD_W'(QUAD_RECIP);
    week_in   = WEEK_IN_W'(a_days_r) + WEEK_IN_W'(EPOCH_WDAY);
    week_prod = WEEK_PROD_W'(week_in) * WEEK_PROD_W'(WEEK_RECIP);
    b_vld_nxt       = a_vld_r;
    b_tod_nxt       = TOD_W'(a_secs_r - day_secs);
    b_day_nxt.days  = a_days_r;
    b_day_nxt.quads = QUAD_W'(quad_prod >> QUAD_SHIFT);
    b_day_nxt.weeks = WEEKS_W'(week_prod >> WEEK_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_secs_r <= a_secs_nxt;
      a_days_r <= a_days_nxt;
      b_tod_r  <= b_tod_nxt;
      b_day_r  <= b_day_nxt;
    end
  end

  assign vld_o = b_vld_r;
  assign tod_o = b_tod_r;
  assign day_o = b_day_r;

endmodule

// File: hdl/u2c_clock.sv
// ----------------------------------------------------------------------------
// u2c_clock: time-of-day split, pipeline stages three to six
// Splits seconds in the day into hour, minute and second, aligned with the
// date path.
// ----------------------------------------------------------------------------
module u2c_clock (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [u2c_pkg::TOD_W-1:0]    tod_i,
  output logic [u2c_pkg::HOUR_W-1:0]   hour_o,
  output logic [u2c_pkg::MIN_W-1:0]    min_o,
  output logic [u2c_pkg::SEC_W-1:0]    sec_o
);
  import u2c_pkg::*;

  logic [HOUR_PROD_W-1:0] hour_prod;
  logic [TOD_W-1:0]       hour_secs;
  logic [MIN_PROD_W-1:0]  min_prod;
  logic [REST_W-1:0]      min_secs;

  logic [TOD_W-1:0]  c_tod_r, c_tod_nxt;
  logic [HOUR_W-1:0] c_hour_r, c_hour_nxt;
  logic [HOUR_W-1:0] d_hour_r, d_hour_nxt;
  logic [REST_W-1:0] d_rest_r, d_rest_nxt;
  logic [HOUR_W-1:0] e_hour_r, e_hour_nxt;
  logic [REST_W-1:0] e_rest_r, e_rest_nxt;
  logic [MIN_W-1:0]  e_min_r, e_min_nxt;
  logic [HOUR_W-1:0] f_hour_r, f_hour_nxt;
  logic [MIN_W-1:0]  f_min_r, f_min_nxt;
  logic [SEC_W-1:0]  f_sec_r, f_sec_nxt;

  always_comb begin
    hour_prod  = HOUR_PROD_W'(tod_i) * HOUR_PROD_W'(HOUR_RECIP);
    c_tod_nxt  = tod_i;
    c_hour_nxt = HOUR_W'(hour_prod >> HOUR_SHIFT);

    hour_secs  = TOD_W'(c_hour_r) * TOD_W'(SECS_PER_HOUR);
    d_hour_nxt = c_hour_r;
    d_rest_nxt = REST_W'(c_tod_r - hour_secs);

    min_prod   = MIN_PROD_W'(d_rest_r) * MIN_PROD_W'(MIN_RECIP);
    e_hour_nxt = d_hour_r;
    e_rest_nxt = d_rest_r;
    e_min_nxt  = MIN_W'(min_prod >> MIN_SHIFT);

    min_secs   = REST_W'(e_min_r) * REST_W'(SECS_PER_MIN);
    f_hour_nxt = e_hour_r;
    f_min_nxt  = e_min_r;
    f_sec_nxt  = SEC_W'(e_rest_r - min_secs);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tod_r  <= c_tod_nxt;
      c_hour_r <= c_hour_nxt;
      d_hour_r <= d_hour_nxt;
      d_rest_r <= d_rest_nxt;
      e_hour_r <= e_hour_nxt;
      e_rest_r <= e_rest_nxt;
      e_min_r  <= e_min_nxt;
      f_hour_r <= f_hour_nxt;
      f_min_r  <= f_min_nxt;
      f_sec_r  <= f_sec_nxt;
    end
  end

  assign hour_o = f_hour_r;
  assign min_o  = f_min_r;
  assign sec_o  = f_sec_r;

endmodule

// File: hdl/u2c_date.sv
// ----------------------------------------------------------------------------
// u2c_date: date path, pipeline stages three to six
// Weekday and day in period, year step-off with the leap rule, month search
// over the cumulative table, then day of month.
// ----------------------------------------------------------------------------
module u2c_date (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_i,
  input  u2c_pkg::u2c_day_t             day_i,
  output logic                          vld_o,
  output logic [u2c_pkg::YEAR_W-1:0]    year_o,
  output logic [u2c_pkg::MONTH_W-1:0]   month_o,
  output logic [u2c_pkg::MDAY_W-1:0]    mday_o,
  output logic [u2c_pkg::WDAY_W-1:0]    wday_o
);
  import u2c_pkg::*;

  logic [DAYS_W-1:0]    quad_days;
  logic [WEEK_IN_W-1:0] week_in;
  logic [WEEK_IN_W-1:0] week_days;
  logic [DOY_W-1:0]     len2;
  logic [DOY_W-1:0]     thr [YEAR_STEPS];
  logic [DOY_W-1:0]     used;
  logic [STEP_W-1:0]    steps;

  logic                 c_vld_r, c_vld_nxt;
  logic [YEAR_W-1:0]    c_year_r, c_year_nxt;
  logic [DOY_W-1:0]     c_doy_r, c_doy_nxt;
  logic [WDAY_W-1:0]    c_wday_r, c_wday_nxt;

  logic                 d_vld_r, d_vld_nxt;
  logic [YEAR_W-1:0]    d_year_r, d_year_nxt;
  logic [DOY9_W-1:0]    d_doy_r, d_doy_nxt;
  logic                 d_leap_r, d_leap_nxt;
  logic [WDAY_W-1:0]    d_wday_r, d_wday_nxt;

  logic                 e_vld_r, e_vld_nxt;
  logic [YEAR_W-1:0]    e_year_r, e_year_nxt;
  logic [DOY9_W-1:0]    e_doy_r, e_doy_nxt;
  logic                 e_leap_r, e_leap_nxt;
  logic [MONTH_W-1:0]   e_month_r, e_month_nxt;
  logic [WDAY_W-1:0]    e_wday_r, e_wday_nxt;

  logic                 f_vld_r, f_vld_nxt;
  logic [YEAR_W-1:0]    f_year_r, f_year_nxt;
  logic [MONTH_W-1:0]   f_month_r, f_month_nxt;
  logic [MDAY_W-1:0]    f_mday_r, f_mday_nxt;
  logic [WDAY_W-1:0]    f_wday_r, f_wday_nxt;

  // Stage three: day in period, base year, weekday
  always_comb begin
    quad_days  = DAYS_W'(day_i.quads) * DAYS_W'(DAYS_PER_QUAD);
    week_in    = WEEK_IN_W'(day_i.days) + WEEK_IN_W'(EPOCH_WDAY);
    week_days  = WEEK_IN_W'(day_i.weeks) * WEEK_IN_W'(DAYS_PER_WEEK);
    c_vld_nxt  = vld_i;
    c_doy_nxt  = DOY_W'(day_i.days - quad_days);
    c_year_nxt = YEAR_W'(BASE_YEAR) + YEAR_W'({day_i.quads, 2'b00});
    c_wday_nxt = WDAY_W'(week_in - week_days);
  end

  // Stage four: step off whole years; the third year of a period is the leap one
  always_comb begin
    len2   = is_leap(c_year_r + YEAR_W'(2)) ? DOY_W'(DAYS_PER_LEAP)
                                             : DOY_W'(DAYS_PER_YEAR);
    thr[0] = DOY_W'(DAYS_PER_YEAR);
    thr[1] = DOY_W'(2 * DAYS_PER_YEAR);
    thr[2] = thr[1] + len2;
    thr[3] = thr[2] + DOY_W'(DAYS_PER_YEAR);
    steps  = '0;
    used   = '0;
    for (int i = 0; i < YEAR_STEPS; i++) begin
      if (c_doy_r >= thr[i]) begin
        steps = STEP_W'(i + 1);
        used  = thr[i];
      end
    end
    d_vld_nxt  = c_vld_r;
    d_year_nxt = c_year_r + YEAR_W'(steps);
    d_leap_nxt = is_leap(d_year_nxt);
    d_doy_nxt  = DOY9_W'(c_doy_r - used);
    d_wday_nxt = c_wday_r;
  end

  // Stage five: last month whose start is at or before the day in year
  always_comb begin
    e_month_nxt = '0;
    for (int m = 1; m < MONTHS; m++) begin
      if (month_start(MONTH_W'(m), d_leap_r) <= d_doy_r) begin
        e_month_nxt = MONTH_W'(m);
      end
    end
    e_vld_nxt  = d_vld_r;
    e_year_nxt = d_year_r;
    e_doy_nxt  = d_doy_r;
    e_leap_nxt = d_leap_r;
    e_wday_nxt = d_wday_r;
  end

  // Stage six: day of month
  always_comb begin
    f_vld_nxt   = e_vld_r;
    f_year_nxt  = e_year_r;
    f_month_nxt = e_month_r;
    f_mday_nxt  = MDAY_W'(e_doy_r - month_start(e_month_r, e_leap_r) + DOY9_W'(1));
    f_wday_nxt  = e_wday_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= c_vld_nxt;
      d_vld_r <= d_vld_nxt;
      e_vld_r <= e_vld_nxt;
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_year_r  <= c_year_nxt;
      c_doy_r   <= c_doy_nxt;
      c_wday_r  <= c_wday_nxt;
      d_year_r  <= d_year_nxt;
      d_doy_r   <= d_doy_nxt;
      d_leap_r  <= d_leap_nxt;
      d_wday_r  <= d_wday_nxt;
      e_year_r  <= e_year_nxt;
      e_doy_r   <= e_doy_nxt;
      e_leap_r  <= e_leap_nxt;
      e_month_r <= e_month_nxt;
      e_wday_r  <= e_wday_nxt;
      f_year_r  <= f_year_nxt;
      f_month_r <= f_month_nxt;
      f_mday_r  <= f_mday_nxt;
      f_wday_r  <= f_wday_nxt;
    end
  end

  assign vld_o   = f_vld_r;
  assign year_o  = f_year_r;
  assign month_o = f_month_r;
  assign mday_o  = f_mday_r;
  assign wday_o  = f_wday_r;

endmodule
